[design/ibc_pkg.sv]
// Shared types, constants and small divide helpers for the in-flight
// backpressure controller. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ibc_pkg;

	localparam int unsigned COOLDOWN_TICKS = 2;
	localparam logic [1:0] COOLDOWN_LOAD = 2'(COOLDOWN_TICKS);

	localparam logic [1:0] KIND_START    = 2'd0;
	localparam logic [1:0] KIND_PRODUCED = 2'd1;
	localparam logic [1:0] KIND_CONSUMED = 2'd2;
	localparam logic [1:0] KIND_TICK     = 2'd3;

	localparam logic [1:0] CFG_WORKER_THREADS = 2'd0;
	localparam logic [1:0] CFG_MIN_PACK_LIMIT = 2'd1;
	localparam logic [1:0] CFG_PACK_BUDGET    = 2'd2;

	localparam logic [1:0] LEVEL_NONE = 2'd0;
	localparam logic [1:0] LEVEL_SOFT = 2'd1;
	localparam logic [1:0] LEVEL_HARD = 2'd2;

	localparam logic [27:0] WINDOW_US       = 28'd250000;
	localparam logic [31:0] MIN_BYTES       = 32'h0400_0000;
	localparam logic [31:0] MAX_BYTES       = 32'h8000_0000;
	localparam logic [39:0] BYTES_SAT       = 40'hFF_FFFF_FFFF;
	localparam logic [12:0] PACK_CEIL       = 13'd4096;
	localparam logic [11:0] START_PACK_CEIL = 12'd2048;
	localparam logic [6:0]  CHUNK_FLOOR     = 7'd4;
	localparam logic [6:0]  CHUNK_CEIL      = 7'd64;
	localparam logic [6:0]  CHUNK_RESET     = 7'd8;
	localparam logic [31:0] AVG_RESET       = 32'd262144;
	localparam logic [12:0] PACK_RESET      = 13'd128;
	localparam logic [8:0]  WT_RESET        = 9'd1;
	localparam logic [11:0] MINPL_RESET     = 12'd128;

	typedef struct packed {
		logic [12:0] pack_limit;
		logic [31:0] byte_limit;
		logic [6:0]  chunk_limit;
	} limits_t;

	typedef struct packed {
		logic [8:0]  worker_threads;
		logic [11:0] min_pack_limit;
		logic [31:0] pack_budget;
	} cfg_t;

	typedef struct packed {
		limits_t     lim;
		logic [15:0] packs;
		logic [39:0] bytes;
		logic [31:0] avg;
		logic        changed;
	} snap_t;

	typedef struct packed {
		limits_t    lim;
		logic       changed;
		logic [1:0] cooldown;
	} tune_res_t;

	typedef struct packed {
		limits_t     lim;
		logic [15:0] packs;
		logic [39:0] bytes;
		logic [44:0] prod;
		logic        changed;
	} s2_t;

	// floor(x/5) by reciprocal, exact for all 32-bit x
	function automatic logic [29:0] div5_32(input logic [31:0] x);
		logic [63:0] p;
		p = 64'(x) * 64'h0000_0000_CCCC_CCCD;
		return p[63:34];
	endfunction

	// floor(x/5), exact below 16384
	function automatic logic [10:0] div5_13(input logic [12:0] x);
		logic [25:0] p;
		p = 26'(x) * 26'd6554;
		return p[25:15];
	endfunction

	// floor(x/6), exact below 128
	function automatic logic [4:0] div6_7(input logic [6:0] x);
		logic [12:0] p;
		p = 13'(x) * 13'd43;
		return p[12:8];
	endfunction

	// floor(x/5), exact below 128
	function automatic logic [4:0] div5_7(input logic [6:0] x);
		logic [13:0] p;
		p = 14'(x) * 14'd103;
		return p[13:9];
	endfunction

endpackage

`default_nettype wire

[design/ibc_tune.sv]
// Autotuner: decides shrink, grow or hold of the limits on a tick.
// Combinational; uses ibc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ibc_tune (
	input  wire ibc_pkg::cfg_t      cfg,
	input  wire ibc_pkg::limits_t   lim,
	input  wire logic [15:0]        packs,
	input  wire logic [39:0]        bytes,
	input  wire logic [1:0]         cooldown,
	input  wire logic [23:0]        bp,
	input  wire logic [27:0]        ww,
	input  wire logic [15:0]        backlog,
	output ibc_pkg::tune_res_t      res
);

	localparam logic [27:0] WINDOW_US_W = ibc_pkg::WINDOW_US;

	logic [8:0]  thr;
	logic [27:0] wwin;
	logic [34:0] wwin35, ww25, ww100;
	logic [27:0] bp10;
	logic [1:0]  cd_dec;
	logic [22:0] packs100, pl90, pl98;
	logic [46:0] bytes100, bl90, bl98;
	logic [16:0] pl3, pl2, backlog17;
	logic        near_cap, hard, moderate, bp_high, bp_low;
	logic        more_feed, less_press, boost, go;

	logic [10:0] pq5, pc10;
	logic [2:0]  pr5;
	logic [12:0] pl_shr, np_shr, np_gr, np;
	logic [13:0] pl_gr;
	logic [29:0] bq5, bc10;
	logic [2:0]  br5;
	logic [31:0] bl_shr, nb_shr, nb_gr, nb;
	logic [32:0] bl_gr;
	logic [4:0]  s6, s5, st6, st5;
	logic [7:0]  rc_gr;
	logic [6:0]  nr_shr, nr_gr, nr;
	logic        changed;

	assign thr    = (cfg.worker_threads == 9'd0) ? 9'd1 : cfg.worker_threads;
	assign wwin   = 28'(thr) * WINDOW_US_W;
	assign wwin35 = 35'(wwin);
	assign ww25   = 35'(ww) * 35'd25;
	assign ww100  = 35'(ww) * 35'd100;
	assign bp10   = 28'(bp) * 28'd10;
	assign cd_dec = (cooldown == 2'd0) ? 2'd0 : cooldown - 2'd1;

	// x > floor(y/100)  <=>  y < 100x
	assign packs100  = 23'(packs) * 23'd100;
	assign pl90      = 23'(lim.pack_limit) * 23'd90;
	assign pl98      = 23'(lim.pack_limit) * 23'd98;
	assign bytes100  = 47'(bytes) * 47'd100;
	assign bl90      = 47'(lim.byte_limit) * 47'd90;
	assign bl98      = 47'(lim.byte_limit) * 47'd98;
	assign pl3       = 17'(lim.pack_limit) * 17'd3;
	assign pl2       = 17'({lim.pack_limit, 1'b0});
	assign backlog17 = 17'(backlog);

	assign near_cap   = (pl90 < packs100) || (bl90 < bytes100);
	assign hard       = (backlog17 > pl3) || (pl98 < packs100) || (bl98 < bytes100);
	assign moderate   = (backlog17 > pl2) || near_cap;
	assign bp_high    = bp10 > 28'd750000;
	assign bp_low     = bp10 < WINDOW_US_W;
	assign more_feed  = (ww25 > wwin35) || (bp_high && !moderate);
	assign less_press = hard && (ww100 < wwin35) && bp_low;
	assign boost      = near_cap && bp_high && (ww25 < wwin35);
	assign go         = (cd_dec == 2'd0);

	// pack limit: 9/10 = x - ceil(x/10), 6/5 = x + floor(x/5), 5/4 = x + x/4
	assign pq5    = ibc_pkg::div5_13(lim.pack_limit);
	assign pr5    = lim.pack_limit[2:0] - 3'(pq5[2:0] * 3'd5);
	assign pc10   = 11'(pq5[10:1]) + (((pr5 == 3'd0) && !pq5[0]) ? 11'd0 : 11'd1);
	assign pl_shr = lim.pack_limit - 13'(pc10);
	assign np_shr = (pl_shr < 13'(cfg.min_pack_limit)) ? 13'(cfg.min_pack_limit) : pl_shr;
	assign pl_gr  = 14'(lim.pack_limit)
		+ (boost ? 14'(lim.pack_limit[12:2]) : 14'(pq5));
	assign np_gr  = (pl_gr > 14'(ibc_pkg::PACK_CEIL)) ? ibc_pkg::PACK_CEIL : pl_gr[12:0];

	assign bq5    = ibc_pkg::div5_32(lim.byte_limit);
	assign br5    = lim.byte_limit[2:0] - 3'(bq5[2:0] * 3'd5);
	assign bc10   = 30'(bq5[29:1]) + (((br5 == 3'd0) && !bq5[0]) ? 30'd0 : 30'd1);
	assign bl_shr = lim.byte_limit - 32'(bc10);
	assign nb_shr = (bl_shr < ibc_pkg::MIN_BYTES) ? ibc_pkg::MIN_BYTES : bl_shr;
	assign bl_gr  = 33'(lim.byte_limit)
		+ (boost ? 33'(lim.byte_limit[31:2]) : 33'(bq5));
	assign nb_gr  = (bl_gr > 33'(ibc_pkg::MAX_BYTES)) ? ibc_pkg::MAX_BYTES : bl_gr[31:0];

	assign s6     = ibc_pkg::div6_7(lim.chunk_limit);
	assign st6    = (s6 == 5'd0) ? 5'd1 : s6;
	assign nr_shr = (8'(lim.chunk_limit) < 8'(st6) + 8'd4) ? ibc_pkg::CHUNK_FLOOR
		: lim.chunk_limit - 7'(st6);
	assign s5     = ibc_pkg::div5_7(lim.chunk_limit);
	assign st5    = (s5 == 5'd0) ? 5'd1 : s5;
	assign rc_gr  = 8'(lim.chunk_limit) + 8'(st5);
	assign nr_gr  = (rc_gr > 8'(ibc_pkg::CHUNK_CEIL)) ? ibc_pkg::CHUNK_CEIL : rc_gr[6:0];

	always_comb begin
		if (go && less_press) begin
			np = np_shr;
			nb = nb_shr;
			nr = nr_shr;
		end else if (go && more_feed) begin
			np = np_gr;
			nb = nb_gr;
			nr = nr_gr;
		end else begin
			np = lim.pack_limit;
			nb = lim.byte_limit;
			nr = lim.chunk_limit;
		end
	end

	assign changed = (np != lim.pack_limit) || (nb != lim.byte_limit)
		|| (nr != lim.chunk_limit);

	assign res.lim.pack_limit  = np;
	assign res.lim.byte_limit  = nb;
	assign res.lim.chunk_limit = nr;
	assign res.changed         = changed;
	assign res.cooldown        = changed ? ibc_pkg::COOLDOWN_LOAD : cd_dec;

endmodule

`default_nettype wire

[design/ibc_state.sv]
// Configuration and controller state registers with the per-request update.
// Uses ibc_pkg and ibc_tune.
`timescale 1ns / 1ps
`default_nettype none

module ibc_state (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        take,
	input  wire logic [1:0]  kind,
	input  wire logic [30:0] raw_bytes,
	input  wire logic [23:0] backpressure_us,
	input  wire logic [27:0] worker_wait_us,
	input  wire logic [15:0] writer_backlog,
	output ibc_pkg::snap_t   snap
);

	ibc_pkg::cfg_t      cfg_q;
	ibc_pkg::limits_t   lim_q;
	logic [15:0]        packs_q;
	logic [39:0]        bytes_q;
	logic [31:0]        avg_q;
	logic [1:0]         cooldown_q;
	logic               changed_s1;
	ibc_pkg::tune_res_t tres;

	logic [14:0] st_sum;
	logic [11:0] st_pl0, st_pl;
	logic [31:0] st_cap;
	logic [31:0] st_bl;
	logic [8:0]  st_rc0;
	logic [6:0]  st_rc;
	logic [40:0] bytes_sum;
	logic [35:0] avg_sum;
	logic [32:0] avg_nxt;

	ibc_tune u_tune (
		.cfg      (cfg_q),
		.lim      (lim_q),
		.packs    (packs_q),
		.bytes    (bytes_q),
		.cooldown (cooldown_q),
		.bp       (backpressure_us),
		.ww       (worker_wait_us),
		.backlog  (writer_backlog),
		.res      (tres)
	);

	assign st_sum = 15'({cfg_q.min_pack_limit, 2'b00}) + 15'({cfg_q.worker_threads, 5'b0});
	assign st_pl0 = (st_sum > 15'(ibc_pkg::START_PACK_CEIL)) ? ibc_pkg::START_PACK_CEIL
		: st_sum[11:0];
	assign st_cap = (cfg_q.pack_budget < 32'd16) ? 32'd16 : cfg_q.pack_budget;
	assign st_pl  = ((cfg_q.pack_budget != 32'd0) && (32'(st_pl0) > st_cap)) ? st_cap[11:0]
		: st_pl0;
	assign st_bl  = (st_pl < 12'd128) ? ibc_pkg::MIN_BYTES : {1'b0, st_pl, 19'b0};
	assign st_rc0 = 9'd8 + 9'(cfg_q.worker_threads[8:1]);
	assign st_rc  = (st_rc0 > 9'(ibc_pkg::CHUNK_CEIL)) ? ibc_pkg::CHUNK_CEIL : st_rc0[6:0];

	assign bytes_sum = 41'(bytes_q) + 41'(raw_bytes);
	assign avg_sum   = 36'(avg_q) * 36'd7 + 36'(raw_bytes);
	assign avg_nxt   = avg_sum[35:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.worker_threads <= ibc_pkg::WT_RESET;
			cfg_q.min_pack_limit <= ibc_pkg::MINPL_RESET;
			cfg_q.pack_budget    <= 32'd0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				ibc_pkg::CFG_WORKER_THREADS: cfg_q.worker_threads <= cfg_wdata[8:0];
				ibc_pkg::CFG_MIN_PACK_LIMIT: cfg_q.min_pack_limit <= cfg_wdata[11:0];
				ibc_pkg::CFG_PACK_BUDGET:    cfg_q.pack_budget    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q.pack_limit  <= ibc_pkg::PACK_RESET;
			lim_q.byte_limit  <= ibc_pkg::MIN_BYTES;
			lim_q.chunk_limit <= ibc_pkg::CHUNK_RESET;
			packs_q           <= 16'd0;
			bytes_q           <= 40'd0;
			avg_q             <= ibc_pkg::AVG_RESET;
			cooldown_q        <= 2'd0;
			changed_s1        <= 1'b0;
		end else if (take) begin
			changed_s1 <= 1'b0;
			case (kind)
				ibc_pkg::KIND_START: begin
					lim_q.pack_limit  <= 13'(st_pl);
					lim_q.byte_limit  <= st_bl;
					lim_q.chunk_limit <= st_rc;
				end
				ibc_pkg::KIND_PRODUCED: begin
					if (packs_q != 16'hFFFF)
						packs_q <= packs_q + 16'd1;
					bytes_q <= (bytes_sum > 41'(ibc_pkg::BYTES_SAT)) ? ibc_pkg::BYTES_SAT
						: bytes_sum[39:0];
					if (avg_nxt != 33'd0)
						avg_q <= avg_nxt[31:0];
				end
				ibc_pkg::KIND_CONSUMED: begin
					if (packs_q != 16'd0)
						packs_q <= packs_q - 16'd1;
					bytes_q <= (bytes_q > 40'(raw_bytes)) ? bytes_q - 40'(raw_bytes) : 40'd0;
				end
				default: begin
					lim_q      <= tres.lim;
					cooldown_q <= tres.cooldown;
					changed_s1 <= tres.changed;
				end
			endcase
		end
	end

	assign snap.lim     = lim_q;
	assign snap.packs   = packs_q;
	assign snap.bytes   = bytes_q;
	assign snap.avg     = avg_q;
	assign snap.changed = changed_s1;

endmodule

`default_nettype wire

[design/ibc_level.sv]
// Pressure level from the in-flight counters, limits and pack-size product.
// Combinational; uses ibc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ibc_level (
	input  wire ibc_pkg::s2_t s2,
	output logic [1:0]        level
);

	logic [46:0] dyn3;
	logic [46:0] half;
	logic [46:0] dyn_lo;
	logic [31:0] dyn;
	logic [21:0] packs50, packs20;
	logic [18:0] pl49, pl17;
	logic [45:0] bytes50, bytes20, dyn49, dyn17;

	assign dyn3   = 47'(s2.prod) * 47'd3;
	assign half   = 47'(s2.lim.byte_limit[31:1]);
	assign dyn_lo = (dyn3 < half) ? half : dyn3;
	assign dyn    = (dyn_lo > 47'(ibc_pkg::MAX_BYTES)) ? ibc_pkg::MAX_BYTES : dyn_lo[31:0];

	assign packs50 = 22'(s2.packs) * 22'd50;
	assign packs20 = 22'(s2.packs) * 22'd20;
	assign pl49    = 19'(s2.lim.pack_limit) * 19'd49;
	assign pl17    = 19'(s2.lim.pack_limit) * 19'd17;
	assign bytes50 = 46'(s2.bytes) * 46'd50;
	assign bytes20 = 46'(s2.bytes) * 46'd20;
	assign dyn49   = 46'(dyn) * 46'd49;
	assign dyn17   = 46'(dyn) * 46'd17;

	always_comb begin
		if (s2.lim.pack_limit == 13'd0 || dyn == 32'd0)
			level = ibc_pkg::LEVEL_NONE;
		else if (packs50 >= 22'(pl49) || bytes50 >= dyn49)
			level = ibc_pkg::LEVEL_HARD;
		else if (packs20 >= 22'(pl17) || bytes20 >= dyn17)
			level = ibc_pkg::LEVEL_SOFT;
		else
			level = ibc_pkg::LEVEL_NONE;
	end

endmodule

`default_nettype wire

[design/inflight_backpressure_controller.sv]
// In-flight backpressure controller, top level: stream ports, pipeline control.
// Result is registered in stages 1, 2 and 3 in turn; one request per cycle
// sustained while m_tready is high. Stage 1 is the state update, stage 2 the
// pack-limit by average product, stage 3 the level compare and output register.
// arst_n resets configuration and state to defaults at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module inflight_backpressure_controller (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wr_en,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_wdata,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// raw_bytes[30:0], backpressure_us[54:31], worker_wait_us[82:55],
	// writer_backlog[98:83], zero pad
	input  wire logic [103:0] s_tdata,
	// kind[1:0]
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// pressure_level[1:0], pack_limit[14:2], byte_limit[46:15],
	// raw_chunk_limit[53:47], limits_changed[54], packs_in_flight[70:55], zero pad
	output logic [71:0]       m_tdata
);

	ibc_pkg::snap_t snap;
	ibc_pkg::s2_t   data_s2;
	logic [1:0]     level;
	logic           v1_s1, v2_s2, v3_s3;
	logic           en1, en2, en3, take;
	logic [71:0]    data_s3;

	assign en3      = !v3_s3 || m_tready;
	assign en2      = !v2_s2 || en3;
	assign en1      = !v1_s1 || en2;
	assign s_tready = en1;
	assign take     = s_tvalid && en1;

	ibc_state u_state (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.take            (take),
		.kind            (s_tuser),
		.raw_bytes       (s_tdata[30:0]),
		.backpressure_us (s_tdata[54:31]),
		.worker_wait_us  (s_tdata[82:55]),
		.writer_backlog  (s_tdata[98:83]),
		.snap            (snap)
	);

	ibc_level u_level (
		.s2    (data_s2),
		.level (level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else begin
			if (en1)
				v1_s1 <= s_tvalid;
			if (en2)
				v2_s2 <= v1_s1;
			if (en3)
				v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			data_s2.lim     <= snap.lim;
			data_s2.packs   <= snap.packs;
			data_s2.bytes   <= snap.bytes;
			data_s2.prod    <= 45'(snap.lim.pack_limit) * 45'(snap.avg);
			data_s2.changed <= snap.changed;
		end
		if (en3)
			data_s3 <= {1'b0, data_s2.packs, data_s2.changed, data_s2.lim.chunk_limit,
				data_s2.lim.byte_limit, data_s2.lim.pack_limit, level};
	end

	assign m_tvalid = v3_s3;
	assign m_tdata  = data_s3;

endmodule

`default_nettype wire
